@@ sv/ptg_pkg.sv @@
`default_nettype none

package ptg_pkg;

    localparam int PIXEL_BITS = 24;
    localparam int FRAC_BITS  = 16;

    localparam int SIZE_W = 11;           // cell_size register
    localparam int OFS_W  = 24;           // view offsets
    localparam int CFG_W  = 24;           // widest register
    localparam int CELL_W = 16;           // result fields

    localparam int SUM_W   = PIXEL_BITS + 1;          // pixel plus offset
    localparam int XMAG_W  = SUM_W - 1 + FRAC_BITS;   // |x| scaled by 2^FRAC_BITS
    localparam int SIDE_W  = SIZE_W + FRAC_BITS;      // size times a Q.FRAC constant
    localparam int QUO_W   = PIXEL_BITS + 2;          // quotient bits, one per divider stage
    localparam int COORD_W = QUO_W + 2;               // signed cell index before saturation
    localparam int PX_W    = SIDE_W + SIZE_W + 1;     // cx * 2 * size
    localparam int PR_W    = SIDE_W + SIZE_W;         // radius * |dev|

    // sqrt3/2 and sqrt3/3 in Q.32, rounded to Q.FRAC_BITS.
    localparam longint SQRT3_DIV2_Q32 = 64'd3719550787;
    localparam longint SQRT3_DIV3_Q32 = 64'd2479700525;
    localparam logic [FRAC_BITS-1:0] K2 =
        FRAC_BITS'((SQRT3_DIV2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] K3 =
        FRAC_BITS'((SQRT3_DIV3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

    // Configuration register indexes.
    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_OFFSET_X  = 2'd1;
    localparam logic [1:0] REG_OFFSET_Y  = 2'd2;
    localparam logic [1:0] REG_HEX_MODE  = 2'd3;

    // Pipeline layout: input stage, divider setup, one stage per quotient bit,
    // then sign fix, products and compare/saturate.
    localparam int ST_IN    = 0;
    localparam int ST_SETUP = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_FIX   = ST_DIV0 + QUO_W;
    localparam int ST_MUL   = ST_FIX + 1;
    localparam int ST_OUT   = ST_MUL + 1;
    localparam int N_STAGES = ST_OUT + 1;

endpackage

`default_nettype wire

@@ sv/pixel_to_grid_cell_pick.sv @@
// Channel   Direction  Signals                                   Fields
// s_        in         s_valid, s_ready                           s_pixel_x, s_pixel_y
// m_        out        m_valid, m_ready                           m_cell_x, m_cell_y
// cfg_      in         cfg_wr_en, cfg_addr, cfg_wdata             register write
//
// Every input transfer gives one result on m_; one item per cycle while m_ready does not stall the output.
// The depth is set by the restoring dividers, one quotient bit per stage (26 stages).
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// Each stage holds while the next one is full and stalled, so empty stages still
// fill behind a stalled result.
`default_nettype none

module pixel_to_grid_cell_pick
    import ptg_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         cfg_wr_en,
    input  wire logic [1:0]                   cfg_addr,
    input  wire logic [CFG_W-1:0]             cfg_wdata,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [PIXEL_BITS-1:0] s_pixel_x,
    input  wire logic signed [PIXEL_BITS-1:0] s_pixel_y,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [CELL_W-1:0]          m_cell_x,
    output logic signed [CELL_W-1:0]          m_cell_y
);

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0]       cell_size_reg;
    logic signed [OFS_W-1:0] offset_x_reg;
    logic signed [OFS_W-1:0] offset_y_reg;
    logic                    hex_mode_reg;
    logic [SIZE_W-1:0]       size_reg;
    logic [SIDE_W-1:0]       side_reg;
    logic [SIDE_W-1:0]       radius_reg;
    logic [SIZE_W-1:0]       size_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= SIZE_W'(16);
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            hex_mode_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CELL_SIZE: cell_size_reg <= cfg_wdata[SIZE_W-1:0];
                REG_OFFSET_X:  offset_x_reg  <= cfg_wdata[OFS_W-1:0];
                REG_OFFSET_Y:  offset_y_reg  <= cfg_wdata[OFS_W-1:0];
                REG_HEX_MODE:  hex_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Derived constants follow in the next cycle; the user must keep the block idle then (not enforced).
    assign size_next = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;

    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        side_reg   <= SIDE_W'(size_next * K2);
        radius_reg <= SIDE_W'(size_next * K3);
    end

    // ---------------- stage flow control ----------------
    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] adv;

    always_comb begin
        adv[N_STAGES-1] = !valid_reg[N_STAGES-1] || m_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[ST_IN]) begin
                valid_reg[ST_IN] <= s_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = adv[ST_IN];
    assign m_valid = valid_reg[ST_OUT];

    // ---------------- input stage: add the viewport offset ----------------
    logic signed [SUM_W-1:0] px_reg;
    logic signed [SUM_W-1:0] py_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_IN]) begin
            px_reg <= SUM_W'(s_pixel_x) + SUM_W'(offset_x_reg);
            py_reg <= SUM_W'(s_pixel_y) + SUM_W'(offset_y_reg);
        end
    end

    // ---------------- divider setup ----------------
    // Floor division of a negative value a works on ~a = -a-1: with
    // ~a = q*d + r, floor(a/d) = ~q and the remainder is d-1-r.
    logic [XMAG_W-1:0]     xnum;
    logic [PIXEL_BITS-1:0] ynum;
    logic [XMAG_W-1:0]     xq_raw;
    logic [XMAG_W-1:0]     xsq_raw;
    logic [SIDE_W-1:0]     xdiv;

    // Per-stage divider state; entry 0 is the setup stage.
    logic [SIDE_W-1:0] xrem_reg [QUO_W+1];
    logic [QUO_W-1:0]  xlo_reg  [QUO_W+1];
    logic [SIZE_W-1:0] yrem_reg [QUO_W+1];
    logic [QUO_W-1:0]  ylo_reg  [QUO_W+1];
    logic              xneg_reg [QUO_W+1];
    logic              yneg_reg [QUO_W+1];

    assign xq_raw  = XMAG_W'(px_reg[SUM_W-2:0]) << FRAC_BITS;
    assign xsq_raw = XMAG_W'(px_reg[SUM_W-2:0]);
    assign xnum    = hex_mode_reg ? (px_reg[SUM_W-1] ? ~xq_raw : xq_raw)
                                  : (px_reg[SUM_W-1]
                                     ? {{(XMAG_W-PIXEL_BITS){1'b0}}, ~px_reg[SUM_W-2:0]}
                                     : xsq_raw);
    assign ynum    = py_reg[SUM_W-1] ? ~py_reg[SUM_W-2:0] : py_reg[SUM_W-2:0];
    assign xdiv    = hex_mode_reg ? side_reg : SIDE_W'(size_reg);

    always_ff @(posedge aclk) begin
        if (adv[ST_SETUP]) begin
            xrem_reg[0] <= SIDE_W'(xnum[XMAG_W-1:QUO_W]);
            xlo_reg[0]  <= xnum[QUO_W-1:0];
            yrem_reg[0] <= '0;
            ylo_reg[0]  <= QUO_W'(ynum);
            xneg_reg[0] <= px_reg[SUM_W-1];
            yneg_reg[0] <= py_reg[SUM_W-1];
        end
    end

    // ---------------- restoring division, one bit per stage ----------------
    // The low register shifts the dividend out and the quotient in.
    logic [SIDE_W:0]   xtry [QUO_W];
    logic [SIZE_W:0]   ytry [QUO_W];
    logic              xge  [QUO_W];
    logic              yge  [QUO_W];

    always_comb begin
        for (int j = 0; j < QUO_W; j++) begin
            xtry[j] = {xrem_reg[j], xlo_reg[j][QUO_W-1]};
            ytry[j] = {yrem_reg[j], ylo_reg[j][QUO_W-1]};
            xge[j]  = xtry[j] >= {1'b0, xdiv};
            yge[j]  = ytry[j] >= {1'b0, size_reg};
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QUO_W; j++) begin
            if (adv[ST_DIV0+j]) begin
                xrem_reg[j+1] <= xge[j] ? SIDE_W'(xtry[j] - {1'b0, xdiv})
                                        : xtry[j][SIDE_W-1:0];
                yrem_reg[j+1] <= yge[j] ? SIZE_W'(ytry[j] - {1'b0, size_reg})
                                        : ytry[j][SIZE_W-1:0];
                xlo_reg[j+1]  <= {xlo_reg[j][QUO_W-2:0], xge[j]};
                ylo_reg[j+1]  <= {ylo_reg[j][QUO_W-2:0], yge[j]};
                xneg_reg[j+1] <= xneg_reg[j];
                yneg_reg[j+1] <= yneg_reg[j];
            end
        end
    end

    // ---------------- sign fix and half-cell row shift ----------------
    // Row of the shifted point: with py = q*s + r, 2*py + s over 2*s is q, or q+1
    // when 2*r >= s, so the one divider serves both column parities.
    logic signed [COORD_W-1:0] ci_fix;
    logic signed [COORD_W-1:0] cj_base;
    logic [SIDE_W-1:0]         cx_fix;
    logic [SIZE_W-1:0]         ry_fix;
    logic [SIZE_W+1:0]         r2;
    logic [SIZE_W+1:0]         cy2;
    logic signed [SIZE_W+2:0]  dev;
    logic                      odd;
    logic                      row_up;

    logic signed [COORD_W-1:0] ci_reg;
    logic signed [COORD_W-1:0] cj_reg;
    logic [SIDE_W-1:0]         cx_reg;
    logic [SIZE_W-1:0]         adev_reg;
    logic                      devneg_reg;
    logic                      odd_reg;

    always_comb begin
        ci_fix  = xneg_reg[QUO_W] ? ~COORD_W'(xlo_reg[QUO_W]) : COORD_W'(xlo_reg[QUO_W]);
        cj_base = yneg_reg[QUO_W] ? ~COORD_W'(ylo_reg[QUO_W]) : COORD_W'(ylo_reg[QUO_W]);
        cx_fix  = xneg_reg[QUO_W] ? SIDE_W'(xdiv - xrem_reg[QUO_W] - SIDE_W'(1))
                                  : xrem_reg[QUO_W];
        ry_fix  = yneg_reg[QUO_W] ? SIZE_W'(size_reg - yrem_reg[QUO_W] - SIZE_W'(1))
                                  : yrem_reg[QUO_W];
        odd     = hex_mode_reg && ci_fix[0];
        r2      = {1'b0, ry_fix, 1'b0};
        row_up  = odd && (r2 >= (SIZE_W+2)'(size_reg));
        if (!odd) begin
            cy2 = r2;
        end else if (row_up) begin
            cy2 = r2 - (SIZE_W+2)'(size_reg);
        end else begin
            cy2 = r2 + (SIZE_W+2)'(size_reg);
        end
        dev = $signed((SIZE_W+3)'(size_reg)) - $signed({1'b0, cy2});
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_FIX]) begin
            ci_reg     <= ci_fix;
            cj_reg     <= cj_base + COORD_W'(row_up);
            cx_reg     <= cx_fix;
            adev_reg   <= dev[SIZE_W+2] ? SIZE_W'(-dev) : SIZE_W'(dev);
            devneg_reg <= dev[SIZE_W+2];
            odd_reg    <= odd;
        end
    end

    // ---------------- corner test products ----------------
    logic [PX_W-1:0]           pcx_reg;
    logic [PR_W-1:0]           prad_reg;
    logic signed [COORD_W-1:0] ci_m_reg;
    logic signed [COORD_W-1:0] cj_m_reg;
    logic                      devneg_m_reg;
    logic                      odd_m_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_MUL]) begin
            pcx_reg      <= PX_W'(cx_reg * {size_reg, 1'b0});
            prad_reg     <= PR_W'(radius_reg * adev_reg);
            ci_m_reg     <= ci_reg;
            cj_m_reg     <= cj_reg;
            devneg_m_reg <= devneg_reg;
            odd_m_reg    <= odd_reg;
        end
    end

    // ---------------- corner adjust and saturation ----------------
    function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [COORD_W:0] v);
        logic signed [COORD_W:0] hi;
        logic signed [COORD_W:0] lo;
        hi = (COORD_W+1)'(2 ** (CELL_W - 1) - 1);
        lo = -(COORD_W+1)'(2 ** (CELL_W - 1));
        if (v > hi) begin
            sat_cell = hi[CELL_W-1:0];
        end else if (v < lo) begin
            sat_cell = lo[CELL_W-1:0];
        end else begin
            sat_cell = v[CELL_W-1:0];
        end
    endfunction

    logic                    corner;
    logic signed [COORD_W:0] ci_adj;
    logic signed [COORD_W:0] cj_adj;
    logic signed [CELL_W-1:0] cell_x_reg;
    logic signed [CELL_W-1:0] cell_y_reg;

    always_comb begin
        corner = hex_mode_reg && (PR_W'(pcx_reg) <= prad_reg) && (pcx_reg[PX_W-1] == 1'b0);
        ci_adj = (COORD_W+1)'(ci_m_reg) - (COORD_W+1)'(corner);
        cj_adj = (COORD_W+1)'(cj_m_reg) - (COORD_W+1)'(corner && odd_m_reg)
               + (COORD_W+1)'(corner && devneg_m_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_OUT]) begin
            cell_x_reg <= sat_cell(ci_adj);
            cell_y_reg <= sat_cell(cj_adj);
        end
    end

    assign m_cell_x = cell_x_reg;
    assign m_cell_y = cell_y_reg;

    // ---------------- assertions ----------------
    // An empty output stage lets every stage move, so input must be open.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[ST_OUT] |-> s_ready)
        else $error("input blocked while output stage is empty");

    // Divider remainders stay below their divisors.
    a_xrem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_FIX-1] |-> (xrem_reg[QUO_W] < xdiv))
        else $error("x remainder out of range");

    a_yrem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_FIX-1] |-> (yrem_reg[QUO_W] < size_reg))
        else $error("y remainder out of range");

    // The distance from the row center never exceeds one cell size.
    a_dev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_FIX] |-> (adev_reg <= size_reg))
        else $error("row deviation out of range");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_cell_x) && $stable(m_cell_y)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
